// ----- sv/efwd_pkg.sv -----
`default_nettype none

package efwd_pkg;

  localparam int NUM_WORKERS = 16;
  localparam int WIDX_W      = $clog2(NUM_WORKERS);
  localparam int RATE_W      = 7;
  localparam int COUNT_W     = 7;
  localparam int PROD_W      = RATE_W + COUNT_W;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 5;
  localparam int STATUS_W    = 2;

  // Accepted range for service rates and item counts
  localparam logic [RATE_W-1:0] RANGE_LO = RATE_W'(1);
  localparam logic [RATE_W-1:0] RANGE_HI = RATE_W'(100);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1);

  typedef enum logic {
    REQ_LOAD_RATE = 1'b0,
    REQ_JOB       = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COUNT = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [TIME_W-1:0] free_time;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [WIDX_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  typedef struct packed {
    logic              valid;
    logic [WIDX_W-1:0] worker;
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] makespan;
    status_e           status;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/efwd_table.sv -----
`default_nettype none

module efwd_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [efwd_pkg::WIDX_W-1:0]  rd_addr_i,
  output efwd_pkg::entry_t             rd_data_o,
  input  efwd_pkg::wr_req_t            wr_i
);
  import efwd_pkg::*;

  entry_t                 mem_q [NUM_WORKERS];
  entry_t                 rd_data_q;
  logic [NUM_WORKERS-1:0] vld_q;
  logic                   rd_vld_q;

  // Storage array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // Entries never written read as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  always_comb begin
    if (rd_vld_q) begin
      rd_data_o = rd_data_q;
    end else begin
      rd_data_o.rate      = RATE_RESET;
      rd_data_o.free_time = '0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/efwd_sched.sv -----
`default_nettype none

module efwd_sched (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [efwd_pkg::CFG_W-1:0]    active_workers_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [efwd_pkg::WIDX_W-1:0]   worker_index_i,
  input  logic [efwd_pkg::RATE_W-1:0]   service_rate_i,
  input  logic [efwd_pkg::COUNT_W-1:0]  item_count_i,
  output logic [efwd_pkg::WIDX_W-1:0]   rd_addr_o,
  input  efwd_pkg::entry_t              rd_data_i,
  output efwd_pkg::wr_req_t             wr_o,
  output efwd_pkg::result_t             res_o,
  input  logic                          res_ready_i
);
  import efwd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [WIDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [WIDX_W-1:0]   last_idx_q, last_idx_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [WIDX_W-1:0]   best_idx_q, best_idx_d;
  logic [TIME_W-1:0]   best_free_q, best_free_d;
  logic [RATE_W-1:0]   best_rate_q, best_rate_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [WIDX_W-1:0]   res_worker_q, res_worker_d;
  logic [TIME_W-1:0]   res_finish_q, res_finish_d;
  status_e             res_status_q, res_status_d;
  logic [TIME_W-1:0]   makespan_q, makespan_d;

  logic [CFG_W-1:0]    n_eff;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   finish;
  logic                rate_ok, count_ok, idx_ok;

  always_comb begin
    if (active_workers_i == '0) begin
      n_eff = CFG_W'(1);
    end else if (32'(active_workers_i) > NUM_WORKERS) begin
      n_eff = CFG_W'(NUM_WORKERS);
    end else begin
      n_eff = active_workers_i;
    end
  end

  assign rate_ok  = (service_rate_i >= RANGE_LO) && (service_rate_i <= RANGE_HI);
  assign count_ok = (item_count_i >= RANGE_LO) && (item_count_i <= RANGE_HI);
  assign idx_ok   = 32'(worker_index_i) < NUM_WORKERS;

  assign sum    = {1'b0, best_free_q} + (TIME_W + 1)'(prod_q);
  assign finish = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cmp_idx_d    = cmp_idx_q;
    last_idx_d   = last_idx_q;
    count_d      = count_q;
    best_idx_d   = best_idx_q;
    best_free_d  = best_free_q;
    best_rate_d  = best_rate_q;
    prod_d       = prod_q;
    res_worker_d = res_worker_q;
    res_finish_d = res_finish_q;
    res_status_d = res_status_q;
    makespan_d   = makespan_q;
    rd_addr_o    = '0;
    wr_o         = '0;
    res_o        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_LOAD_RATE) begin
            if (rate_ok && idx_ok) begin
              wr_o.we             = 1'b1;
              wr_o.addr           = worker_index_i;
              wr_o.data.rate      = service_rate_i;
              wr_o.data.free_time = '0;
              makespan_d          = '0;
            end
          end else if (!count_ok) begin
            res_worker_d = '0;
            res_finish_d = '0;
            res_status_d = STATUS_BAD_COUNT;
            state_d      = ST_OUT;
          end else begin
            count_d    = item_count_i;
            last_idx_d = WIDX_W'(n_eff - CFG_W'(1));
            cmp_idx_d  = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Entry cmp_idx_q is on the read port; fetch the next one
        rd_addr_o = cmp_idx_q + WIDX_W'(1);
        if ((cmp_idx_q == '0) || (rd_data_i.free_time < best_free_q)) begin
          best_idx_d  = cmp_idx_q;
          best_free_d = rd_data_i.free_time;
          best_rate_d = rd_data_i.rate;
        end
        if (cmp_idx_q == last_idx_q) begin
          state_d = ST_MUL;
        end else begin
          cmp_idx_d = cmp_idx_q + WIDX_W'(1);
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(count_q) * PROD_W'(best_rate_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        wr_o.we             = 1'b1;
        wr_o.addr           = best_idx_q;
        wr_o.data.rate      = best_rate_q;
        wr_o.data.free_time = finish;
        if (finish > makespan_q) begin
          makespan_d = finish;
        end
        res_worker_d = best_idx_q;
        res_finish_d = finish;
        res_status_d = sum[TIME_W] ? STATUS_SATURATED : STATUS_OK;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        res_o.valid    = 1'b1;
        res_o.worker   = res_worker_q;
        res_o.finish   = res_finish_q;
        res_o.makespan = makespan_q;
        res_o.status   = res_status_q;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      makespan_q <= '0;
    end else begin
      state_q    <= state_d;
      makespan_q <= makespan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    last_idx_q   <= last_idx_d;
    count_q      <= count_d;
    best_idx_q   <= best_idx_d;
    best_free_q  <= best_free_d;
    best_rate_q  <= best_rate_d;
    prod_q       <= prod_d;
    res_worker_q <= res_worker_d;
    res_finish_q <= res_finish_d;
    res_status_q <= res_status_d;
  end

endmodule

`default_nettype wire

// ----- sv/earliest_free_worker_dispatch.sv -----
// Earliest-free worker dispatcher.
// Input channel (in_valid_i / in_stall_o): one request per transfer. A rate
// load (req_type_i = 0) with a rate in range sets one worker's rate, clears its
// free time and the makespan, and gives no result. A job (req_type_i = 1) goes
// to the earliest-free active worker (lowest index on a tie); one result each.
// Output channel (out_valid_o / out_stall_i): assigned worker, finish time,
// running makespan and status, held in an output register.
// Configuration channel (cfg_valid_i / cfg_ready_o): writes active_workers;
// always ready, write only while no request is in flight.
// Sequence: a rate load writes the worker table directly from the idle state. A
// job scans the active workers (1 to 16) for the earliest free time; the worker
// table sits in one single-port-read memory, so the minimum search reads one
// entry per cycle, then a multiply state and an add state that writes back
// follow. A count outside range goes straight to the output state.
// A stalled receiver holds the output register; the block still takes one
// more request and parks its result until the register frees.
// Reset: all workers rate 1 and free at time 0, makespan 0, active_workers 1.
`default_nettype none

module earliest_free_worker_dispatch (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [efwd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [efwd_pkg::WIDX_W-1:0]      worker_index_i,
  input  logic [efwd_pkg::RATE_W-1:0]      service_rate_i,
  input  logic [efwd_pkg::COUNT_W-1:0]     item_count_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [efwd_pkg::WIDX_W-1:0]      assigned_worker_o,
  output logic [efwd_pkg::TIME_W-1:0]      finish_time_o,
  output logic [efwd_pkg::TIME_W-1:0]      makespan_o,
  output logic [efwd_pkg::STATUS_W-1:0]    status_o
);
  import efwd_pkg::*;

  logic [CFG_W-1:0]    active_workers_q;
  logic [WIDX_W-1:0]   rd_addr;
  entry_t              rd_data;
  wr_req_t             wr_req;
  result_t             res;
  logic                res_ready;

  logic                out_valid_q;
  logic [WIDX_W-1:0]   out_worker_q;
  logic [TIME_W-1:0]   out_finish_q;
  logic [TIME_W-1:0]   out_makespan_q;
  status_e             out_status_q;

  // Configuration register: always ready, one write per transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_workers_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_workers_q <= cfg_wdata_i;
    end
  end

  // Worker table: rate and free time for every worker
  efwd_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr_req)
  );

  // Sequencer: scan for the minimum, multiply-add, write back
  efwd_sched u_sched (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .active_workers_i (active_workers_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .worker_index_i   (worker_index_i),
    .service_rate_i   (service_rate_i),
    .item_count_i     (item_count_i),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .wr_o             (wr_req),
    .res_o            (res),
    .res_ready_i      (res_ready)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_worker_q   <= res.worker;
      out_finish_q   <= res.finish;
      out_makespan_q <= res.makespan;
      out_status_q   <= res.status;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign assigned_worker_o = out_worker_q;
  assign finish_time_o     = out_finish_q;
  assign makespan_o        = out_makespan_q;
  assign status_o          = out_status_q;

endmodule

`default_nettype wire

// ----- sv/efwd_checker.sv -----
`default_nettype none

module efwd_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic [efwd_pkg::WIDX_W-1:0]      assigned_worker_o,
  input  logic [efwd_pkg::TIME_W-1:0]      finish_time_o,
  input  logic [efwd_pkg::TIME_W-1:0]      makespan_o,
  input  logic [efwd_pkg::STATUS_W-1:0]    status_o
);
  import efwd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Bad count carries no assignment
  a_bad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_BAD_COUNT) |->
      (assigned_worker_o == '0) && (finish_time_o == '0))
    else $error("bad count result carries an assignment");

  // Makespan never falls below the finish time of an assigned job
  a_makespan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_BAD_COUNT) |-> (finish_time_o <= makespan_o))
    else $error("makespan below finish time");

  // Saturation pins both times at the maximum
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_SATURATED) |->
      (finish_time_o == '1) && (makespan_o == '1))
    else $error("saturated result not at maximum");

endmodule

bind earliest_free_worker_dispatch efwd_checker u_checker (.*);

`default_nettype wire
